>>> src/assert_macros.svh
// Assertion macros used by the RTL of the local/stack transfer unit.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define JLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/jlstu_pkg.sv
// Shared types, opcodes, status codes and the opcode decoder of the
// local/stack transfer unit. Depends on nothing.
package jlstu_pkg;

  // Result status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_OVER   = 3'd1;
  localparam logic [2:0] ST_UNDER  = 3'd2;
  localparam logic [2:0] ST_BADLOC = 3'd3;
  localparam logic [2:0] ST_UNSUP  = 3'd4;

  // Operation kinds
  localparam logic [1:0] K_NONE  = 2'd0;
  localparam logic [1:0] K_PUSH  = 2'd1;
  localparam logic [1:0] K_LOAD  = 2'd2;
  localparam logic [1:0] K_STORE = 2'd3;

  // Push source select
  localparam logic [1:0] PS_C0  = 2'd0;
  localparam logic [1:0] PS_C1  = 2'd1;
  localparam logic [1:0] PS_LOC = 2'd2;

  // Opcodes
  localparam logic [7:0] OP_ACONST_NULL = 8'h01;
  localparam logic [7:0] OP_ICONST_M1   = 8'h02;
  localparam logic [7:0] OP_ICONST_5    = 8'h08;
  localparam logic [7:0] OP_LCONST_0    = 8'h09;
  localparam logic [7:0] OP_LCONST_1    = 8'h0A;
  localparam logic [7:0] OP_FCONST_0    = 8'h0B;
  localparam logic [7:0] OP_FCONST_1    = 8'h0C;
  localparam logic [7:0] OP_FCONST_2    = 8'h0D;
  localparam logic [7:0] OP_DCONST_0    = 8'h0E;
  localparam logic [7:0] OP_DCONST_1    = 8'h0F;
  localparam logic [7:0] OP_BIPUSH      = 8'h10;
  localparam logic [7:0] OP_SIPUSH      = 8'h11;
  localparam logic [7:0] OP_ILOAD       = 8'h15;
  localparam logic [7:0] OP_ALOAD       = 8'h19;
  localparam logic [7:0] OP_ILOAD_0     = 8'h1A;
  localparam logic [7:0] OP_ALOAD_3     = 8'h2D;
  localparam logic [7:0] OP_ISTORE      = 8'h36;
  localparam logic [7:0] OP_ASTORE      = 8'h3A;
  localparam logic [7:0] OP_ISTORE_0    = 8'h3B;
  localparam logic [7:0] OP_ASTORE_3    = 8'h4E;

  // IEEE-754 constant bit patterns and the iconst bias
  localparam logic [31:0] FCONST1_BITS = 32'h3F80_0000;
  localparam logic [31:0] FCONST2_BITS = 32'h4000_0000;
  localparam logic [31:0] DCONST1_HI   = 32'h3FF0_0000;
  localparam logic [31:0] ICONST_BIAS  = 32'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic        two;
    logic [7:0]  idx;
    logic [31:0] c0;   // pushed first
    logic [31:0] c1;
  } dec_t;

  // Controller -> datapath
  typedef struct packed {
    logic       latch_in;
    logic       check;
    logic       push_en;
    logic [1:0] push_src;
    logic       pop_en;
    logic       fill_en;
    logic       loc_rd_en;
    logic       loc_sel_hi;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [1:0] kind;
    logic       two;
    logic [2:0] err;
  } sts_t;

  // Type code 1 (long) and 3 (double) move two words
  function automatic logic is_two(input logic [2:0] t);
    return t[0] & ~t[2];
  endfunction

  function automatic dec_t decode(input logic [7:0] act, input logic [7:0] hi,
                                  input logic [7:0] lo);
    dec_t       d;
    logic [7:0] r;
    d = '0;
    r = '0;
    if (act == OP_ACONST_NULL) begin
      d.kind = K_PUSH;
    end else if (act >= OP_ICONST_M1 && act <= OP_ICONST_5) begin
      d.kind = K_PUSH;
      d.c0   = {24'h0, act} - ICONST_BIAS;
    end else if (act == OP_LCONST_0 || act == OP_DCONST_0) begin
      d.kind = K_PUSH;
      d.two  = 1'b1;
    end else if (act == OP_LCONST_1) begin
      d.kind = K_PUSH;
      d.two  = 1'b1;
      d.c1   = 32'd1;
    end else if (act == OP_FCONST_0) begin
      d.kind = K_PUSH;
    end else if (act == OP_FCONST_1) begin
      d.kind = K_PUSH;
      d.c0   = FCONST1_BITS;
    end else if (act == OP_FCONST_2) begin
      d.kind = K_PUSH;
      d.c0   = FCONST2_BITS;
    end else if (act == OP_DCONST_1) begin
      d.kind = K_PUSH;
      d.two  = 1'b1;
      d.c0   = DCONST1_HI;
    end else if (act == OP_BIPUSH) begin
      d.kind = K_PUSH;
      d.c0   = {{24{hi[7]}}, hi};
    end else if (act == OP_SIPUSH) begin
      d.kind = K_PUSH;
      d.c0   = {{16{hi[7]}}, hi, lo};
    end else if (act >= OP_ILOAD && act <= OP_ALOAD) begin
      r      = act - OP_ILOAD;
      d.kind = K_LOAD;
      d.idx  = hi;
      d.two  = is_two(r[2:0]);
    end else if (act >= OP_ILOAD_0 && act <= OP_ALOAD_3) begin
      r      = act - OP_ILOAD_0;
      d.kind = K_LOAD;
      d.idx  = {6'd0, r[1:0]};
      d.two  = is_two(r[4:2]);
    end else if (act >= OP_ISTORE && act <= OP_ASTORE) begin
      r      = act - OP_ISTORE;
      d.kind = K_STORE;
      d.idx  = hi;
      d.two  = is_two(r[2:0]);
    end else if (act >= OP_ISTORE_0 && act <= OP_ASTORE_3) begin
      r      = act - OP_ISTORE_0;
      d.kind = K_STORE;
      d.idx  = {6'd0, r[1:0]};
      d.two  = is_two(r[4:2]);
    end
    return d;
  endfunction

endpackage

>>> src/jlstu_ctrl.sv
// Sequencer of the local/stack transfer unit: one item at a time through
// decode, word moves and the result beat. Depends on jlstu_pkg.
module jlstu_ctrl
  import jlstu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output logic out_valid,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_PUSH0 = 4'd2;
  localparam logic [3:0] S_PUSH1 = 4'd3;
  localparam logic [3:0] S_LD0   = 4'd4;
  localparam logic [3:0] S_LD1   = 4'd5;
  localparam logic [3:0] S_POP0  = 4'd6;
  localparam logic [3:0] S_FILL0 = 4'd7;
  localparam logic [3:0] S_POP1  = 4'd8;
  localparam logic [3:0] S_FILL1 = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DEC;
        end
      end
      S_DEC: begin
        cmd.check = 1'b1;
        if (sts.err != ST_OK) begin
          state_nxt = S_DONE;
        end else if (sts.kind == K_LOAD) begin
          cmd.loc_rd_en = 1'b1;
          state_nxt     = S_LD0;
        end else if (sts.kind == K_STORE) begin
          state_nxt = S_POP0;
        end else begin
          state_nxt = S_PUSH0;
        end
      end
      S_PUSH0: begin
        cmd.push_en  = 1'b1;
        cmd.push_src = PS_C0;
        state_nxt    = sts.two ? S_PUSH1 : S_DONE;
      end
      S_PUSH1: begin
        cmd.push_en  = 1'b1;
        cmd.push_src = PS_C1;
        state_nxt    = S_DONE;
      end
      S_LD0: begin
        cmd.push_en  = 1'b1;
        cmd.push_src = PS_LOC;
        if (sts.two) begin
          cmd.loc_rd_en  = 1'b1;
          cmd.loc_sel_hi = 1'b1;
          state_nxt      = S_LD1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_LD1: begin
        cmd.push_en  = 1'b1;
        cmd.push_src = PS_LOC;
        state_nxt    = S_DONE;
      end
      S_POP0: begin
        cmd.pop_en     = 1'b1;
        cmd.loc_sel_hi = sts.two;
        state_nxt      = S_FILL0;
      end
      S_FILL0: begin
        cmd.fill_en = 1'b1;
        state_nxt   = sts.two ? S_POP1 : S_DONE;
      end
      S_POP1: begin
        cmd.pop_en = 1'b1;
        state_nxt  = S_FILL1;
      end
      S_FILL1: begin
        cmd.fill_en = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/jlstu_dp.sv
// Datapath of the local/stack transfer unit: operand latch, decode and
// checks, stack memory with cached top two words, local file with valid bits.
// Depends on jlstu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jlstu_dp
  import jlstu_pkg::*;
#(
  parameter int STACK_WORDS = 64,
  parameter int LOCAL_SLOTS = 256
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_action,
  input  logic [7:0]  in_operand_hi,
  input  logic [7:0]  in_operand_lo,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [2:0]  status,
  output logic [31:0] top_word,
  output logic [31:0] below_word,
  output logic [6:0]  stack_depth
);

  localparam int SP_W = $clog2(STACK_WORDS + 1);
  localparam int AW   = $clog2(STACK_WORDS);
  localparam int LW   = $clog2(LOCAL_SLOTS);

  logic [7:0]  act_r, hi_r, lo_r;
  logic [8:0]  locals_r;
  logic [2:0]  status_r;
  logic [SP_W-1:0] sp_r;
  logic [31:0] top_r, below_r;

  logic [31:0] stk_mem [STACK_WORDS];
  logic [31:0] stk_rdata_r;
  logic [31:0] loc_mem [LOCAL_SLOTS];
  logic [LOCAL_SLOTS-1:0] loc_vld_r;
  logic [31:0] loc_rdata_r;
  logic        loc_rvld_r;

  dec_t        dec;
  logic [8:0]  limit;
  logic [9:0]  need;
  logic [SP_W:0] words;
  logic [2:0]  err;
  logic [LW-1:0] loc_addr;
  logic [31:0] loc_word;
  logic [31:0] push_val;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      act_r <= in_action;
      hi_r  <= in_operand_hi;
      lo_r  <= in_operand_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locals_r <= 9'd256;
    end else if (cfg_wr_en) begin
      locals_r <= cfg_wr_data;
    end
  end

  // Decode and checks: unsupported, then local index, then stack
  always_comb begin
    dec   = decode(act_r, hi_r, lo_r);
    limit = (locals_r < 9'(LOCAL_SLOTS)) ? locals_r : 9'(LOCAL_SLOTS);
    need  = {2'b00, dec.idx} + {9'd0, dec.two} + 10'd1;
    words = dec.two ? (SP_W+1)'(2) : (SP_W+1)'(1);
    if (dec.kind == K_NONE) begin
      err = ST_UNSUP;
    end else if (dec.kind != K_PUSH && need > {1'b0, limit}) begin
      err = ST_BADLOC;
    end else if (dec.kind == K_STORE) begin
      err = ({1'b0, sp_r} < words) ? ST_UNDER : ST_OK;
    end else begin
      err = ({1'b0, sp_r} + words > (SP_W+1)'(STACK_WORDS)) ? ST_OVER : ST_OK;
    end
  end

  assign sts.kind = dec.kind;
  assign sts.two  = dec.two;
  assign sts.err  = err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= ST_OK;
    end else if (cmd.check) begin
      status_r <= err;
    end
  end

  // Local file
  assign loc_addr = dec.idx[LW-1:0] + LW'(cmd.loc_sel_hi);
  assign loc_word = loc_rvld_r ? loc_rdata_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.pop_en) begin
      loc_mem[loc_addr] <= top_r;
    end
    if (cmd.loc_rd_en) begin
      loc_rdata_r <= loc_mem[loc_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_vld_r  <= '0;
      loc_rvld_r <= 1'b0;
    end else begin
      if (cmd.pop_en) begin
        loc_vld_r[loc_addr] <= 1'b1;
      end
      if (cmd.loc_rd_en) begin
        loc_rvld_r <= loc_vld_r[loc_addr];
      end
    end
  end

  // Operand stack: memory holds every word, top two also cached
  always_comb begin
    unique case (cmd.push_src)
      PS_C0:   push_val = dec.c0;
      PS_C1:   push_val = dec.c1;
      PS_LOC:  push_val = loc_word;
      default: push_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.push_en) begin
      stk_mem[sp_r[AW-1:0]] <= push_val;
    end
    if (cmd.pop_en) begin
      stk_rdata_r <= stk_mem[AW'(sp_r - SP_W'(3))];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r    <= '0;
      top_r   <= '0;
      below_r <= '0;
    end else if (cmd.push_en) begin
      sp_r    <= sp_r + SP_W'(1);
      top_r   <= push_val;
      below_r <= top_r;
    end else if (cmd.pop_en) begin
      sp_r    <= sp_r - SP_W'(1);
      top_r   <= below_r;
      below_r <= '0;
    end else if (cmd.fill_en) begin
      below_r <= (sp_r >= SP_W'(2)) ? stk_rdata_r : '0;
    end
  end

  assign status      = status_r;
  assign top_word    = top_r;
  assign below_word  = below_r;
  assign stack_depth = 7'(sp_r);

  `JLS_ASSERT_IMP(a_sp_range, clk, rst_n, 1'b1, sp_r <= SP_W'(STACK_WORDS), "depth beyond stack size")
  `JLS_ASSERT_IMP(a_below_zero, clk, rst_n, sp_r < SP_W'(2), below_r == '0, "stale below word")
  `JLS_ASSERT_IMP(a_top_zero, clk, rst_n, sp_r == '0, top_r == '0, "stale top word")
  `JLS_ASSERT_IMP(a_pop_nonempty, clk, rst_n, cmd.pop_en, sp_r != '0, "pop from empty stack")
  `JLS_ASSERT_NXT(a_push_step, clk, rst_n, cmd.push_en, sp_r == $past(sp_r) + SP_W'(1), "push lost")

endmodule

>>> src/jvm_local_stack_transfer_unit.sv
// Top level of the local/stack transfer unit: controller plus datapath.
// Depends on jlstu_pkg, jlstu_ctrl and jlstu_dp.
//
// Executes one JVM constant push, bipush/sipush, local load or local store
// per command beat. Raise start with the opcode and both operand bytes; the
// beat is taken on the edge where start is high and busy is low. Exactly one
// result beat follows, shown for a single cycle on out_valid; the receiver
// cannot stall it, so capture it on that cycle. The result gives the status
// and the top two stack words and depth after the step (unchanged stack on
// any error). The block works one command at a time: it takes no new command
// until busy has fallen after the result beat. Two-word moves cost more
// because each word goes through the single write or read port of the stack
// and local memories; stores also refill the cached word below the top from
// stack memory after each pop. Write cfg_wr_data to set the number of valid
// local slots (reset 256) only while busy is low. No clearing pass is needed
// after reset: local slots carry valid bits and read as zero until first
// stored.
module jvm_local_stack_transfer_unit
  import jlstu_pkg::*;
#(
  parameter int STACK_WORDS = 64,
  parameter int LOCAL_SLOTS = 256
)(
  input  logic        clk,
  input  logic        rst_n,
  // command beat
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_action,
  input  logic [7:0]  in_operand_hi,
  input  logic [7:0]  in_operand_lo,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,
  // result beat
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_top_word,
  output logic [31:0] out_below_word,
  output logic [6:0]  out_stack_depth
);

  cmd_t cmd;
  sts_t sts;

  // Sequence each command: decode, move words, strobe result
  jlstu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold operands, stack, locals and result registers
  jlstu_dp #(
    .STACK_WORDS (STACK_WORDS),
    .LOCAL_SLOTS (LOCAL_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_action     (in_action),
    .in_operand_hi (in_operand_hi),
    .in_operand_lo (in_operand_lo),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .cmd           (cmd),
    .sts           (sts),
    .status        (out_status),
    .top_word      (out_top_word),
    .below_word    (out_below_word),
    .stack_depth   (out_stack_depth)
  );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for jvm_local_stack_transfer_unit: directed and random
// bytecode beats, a clocked driver and monitor, and an in-bench stack/locals model.
// Depends on jlstu_pkg and the RTL of the unit only.
module testbench;
  import jlstu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_WORDS      = 64;
  localparam int LOCAL_SLOTS      = 256;
  localparam int IDLE_PCT         = 22;
  localparam int NOISE_PCT        = 10;
  localparam int RANDOM_PER_PHASE = 125;
  localparam int PHASES           = 6;
  localparam int CALM_PHASE       = 3;
  localparam int TAIL_CYCLES      = 20;
  localparam int CYCLE_LIMIT      = 100000;

  // Opcodes the package does not name
  localparam logic [7:0] OP_NOP      = 8'h00;
  localparam logic [7:0] OP_ICONST_0 = 8'h03;
  localparam logic [7:0] OP_LDC      = 8'h12;
  localparam logic [7:0] OP_LLOAD    = 8'h16;
  localparam logic [7:0] OP_DLOAD    = 8'h18;
  localparam logic [7:0] OP_LSTORE   = 8'h37;
  localparam logic [7:0] OP_DSTORE   = 8'h39;
  localparam logic [7:0] OP_DSTORE_2 = 8'h49;
  localparam logic [7:0] OP_ILLEGAL  = 8'hFF;

  // Value type codes inside a load/store group that move two words
  localparam logic [2:0] TYPE_LONG   = 3'd1;
  localparam logic [2:0] TYPE_DOUBLE = 3'd3;

  typedef struct packed {
    logic [7:0] action;
    logic [7:0] hi;
    logic [7:0] lo;
  } bytecode_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] top;
    logic [31:0] below;
    logic [6:0]  depth;
  } frame_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  in_action = '0;
  logic [7:0]  in_operand_hi = '0;
  logic [7:0]  in_operand_lo = '0;
  logic        cfg_wr_en = 1'b0;
  logic [8:0]  cfg_wr_data = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_top_word;
  logic [31:0] out_below_word;
  logic [6:0]  out_stack_depth;

  // Mirror of the unit's architectural state
  logic [31:0] stack_mirror [STACK_WORDS];
  logic [31:0] local_mirror [LOCAL_SLOTS];
  int          stack_ptr;
  int          locals_limit;

  bytecode_t   pending_cmds [$];
  frame_view_t expected_views [$];

  bit          beat_taken;
  bit          calm_stretch;
  int          mismatches;
  int          beats_accepted;
  int          results_seen;
  int          settings_used;
  int          cycle_count;
  int          status_hits [8];

  jvm_local_stack_transfer_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_operand_hi   (in_operand_hi),
    .in_operand_lo   (in_operand_lo),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_top_word    (out_top_word),
    .out_below_word  (out_below_word),
    .out_stack_depth (out_stack_depth)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit moves_two_words(input logic [2:0] value_type);
    return value_type == TYPE_LONG || value_type == TYPE_DOUBLE;
  endfunction

  // Execute one bytecode on the mirror and return the frame the unit should report.
  // Decode first, then check in the unit's order: unsupported, local index, stack.
  function automatic frame_view_t exec_bytecode(input logic [7:0] act, input logic [7:0] hi,
                                                input logic [7:0] lo);
    logic [1:0]  kind;
    logic [7:0]  rel;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic [2:0]  status;
    int          words;
    int          idx;
    int          limit;
    frame_view_t view;
    kind        = K_NONE;
    rel         = '0;
    first_word  = '0;
    second_word = '0;
    status      = ST_OK;
    words       = 1;
    idx         = 0;
    if (act == OP_ACONST_NULL || act == OP_FCONST_0) begin
      kind = K_PUSH;
    end else if (act >= OP_ICONST_M1 && act <= OP_ICONST_5) begin
      kind       = K_PUSH;
      first_word = 32'(act) - 32'(OP_ICONST_0);
    end else if (act == OP_LCONST_0 || act == OP_DCONST_0) begin
      kind  = K_PUSH;
      words = 2;
    end else if (act == OP_LCONST_1) begin
      // high word zero goes in first, so the one ends on top
      kind        = K_PUSH;
      words       = 2;
      second_word = 32'd1;
    end else if (act == OP_FCONST_1) begin
      kind       = K_PUSH;
      first_word = FCONST1_BITS;
    end else if (act == OP_FCONST_2) begin
      kind       = K_PUSH;
      first_word = FCONST2_BITS;
    end else if (act == OP_DCONST_1) begin
      kind       = K_PUSH;
      words      = 2;
      first_word = DCONST1_HI;
    end else if (act == OP_BIPUSH) begin
      kind       = K_PUSH;
      first_word = 32'(signed'(hi));
    end else if (act == OP_SIPUSH) begin
      kind       = K_PUSH;
      first_word = 32'(signed'({hi, lo}));
    end else if (act >= OP_ILOAD && act <= OP_ALOAD) begin
      rel   = act - OP_ILOAD;
      kind  = K_LOAD;
      idx   = hi;
      words = moves_two_words(rel[2:0]) ? 2 : 1;
    end else if (act >= OP_ILOAD_0 && act <= OP_ALOAD_3) begin
      rel   = act - OP_ILOAD_0;
      kind  = K_LOAD;
      idx   = rel % 4;
      words = moves_two_words(3'(rel / 4)) ? 2 : 1;
    end else if (act >= OP_ISTORE && act <= OP_ASTORE) begin
      rel   = act - OP_ISTORE;
      kind  = K_STORE;
      idx   = hi;
      words = moves_two_words(rel[2:0]) ? 2 : 1;
    end else if (act >= OP_ISTORE_0 && act <= OP_ASTORE_3) begin
      rel   = act - OP_ISTORE_0;
      kind  = K_STORE;
      idx   = rel % 4;
      words = moves_two_words(3'(rel / 4)) ? 2 : 1;
    end

    limit = locals_limit < LOCAL_SLOTS ? locals_limit : LOCAL_SLOTS;

    if (kind == K_NONE) begin
      status = ST_UNSUP;
    end else if (kind != K_PUSH && idx + words > limit) begin
      status = ST_BADLOC;
    end else if (kind == K_STORE) begin
      if (stack_ptr < words) begin
        status = ST_UNDER;
      end else if (words == 2) begin
        local_mirror[idx + 1] = stack_mirror[stack_ptr - 1];
        local_mirror[idx]     = stack_mirror[stack_ptr - 2];
        stack_ptr -= 2;
      end else begin
        local_mirror[idx] = stack_mirror[stack_ptr - 1];
        stack_ptr -= 1;
      end
    end else if (stack_ptr + words > STACK_WORDS) begin
      status = ST_OVER;
    end else begin
      if (kind == K_LOAD) begin
        first_word = local_mirror[idx];
        if (words == 2) second_word = local_mirror[idx + 1];
      end
      stack_mirror[stack_ptr] = first_word;
      stack_ptr += 1;
      if (words == 2) begin
        stack_mirror[stack_ptr] = second_word;
        stack_ptr += 1;
      end
    end

    view.status = status;
    view.top    = stack_ptr >= 1 ? stack_mirror[stack_ptr - 1] : '0;
    view.below  = stack_ptr >= 2 ? stack_mirror[stack_ptr - 2] : '0;
    view.depth  = 7'(stack_ptr);
    return view;
  endfunction

  // Favor the edges of the valid local range, where bad-index errors live.
  function automatic logic [7:0] pick_local_index(input int limit);
    int v;
    case ($urandom_range(0, 3))
      0: begin
        v = $urandom_range(0, 7);
      end
      1: begin
        v = limit - 2 + $urandom_range(0, 2);
      end
      default: begin
        v = $urandom_range(0, 255);
      end
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Mostly well-formed traffic; noise is a fully random byte triple.
  function automatic bytecode_t random_bytecode(input int store_pct, input int limit);
    bytecode_t b;
    int        roll;
    b.hi   = 8'($urandom_range(0, 255));
    b.lo   = 8'($urandom_range(0, 255));
    roll   = $urandom_range(0, 99);
    if (roll < NOISE_PCT) begin
      b.action = 8'($urandom_range(0, 255));
    end else if (roll < NOISE_PCT + store_pct) begin
      b.action = $urandom_range(0, 1) ? 8'($urandom_range(OP_ISTORE, OP_ASTORE))
                                      : 8'($urandom_range(OP_ISTORE_0, OP_ASTORE_3));
      b.hi     = pick_local_index(limit);
    end else if ($urandom_range(0, 1)) begin
      b.action = 8'($urandom_range(OP_ACONST_NULL, OP_SIPUSH));
    end else begin
      b.action = $urandom_range(0, 1) ? 8'($urandom_range(OP_ILOAD, OP_ALOAD))
                                      : 8'($urandom_range(OP_ILOAD_0, OP_ALOAD_3));
      b.hi     = pick_local_index(limit);
    end
    return b;
  endfunction

  task automatic queue_cmd(input logic [7:0] act, input logic [7:0] hi, input logic [7:0] lo);
    pending_cmds.push_back('{act, hi, lo});
  endtask

  // Hold until every queued beat went in, every result came back and the unit is idle.
  // Sample at the rising edge, where the driver is quiet, then return at a falling edge.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || expected_views.size() != 0 || start || busy);
    @(negedge clk);
  endtask

  // Write the local-slot count; only called with the unit idle.
  task automatic program_locals(input int slots);
    cfg_wr_data  <= 9'(slots);
    cfg_wr_en    <= 1'b1;
    locals_limit  = slots;
    settings_used++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Driver: present a new beat at the falling edge once the last one was taken,
  // skipping about a fifth of the chances except during the calm stretch.
  always @(negedge clk) begin : cmd_driver
    bytecode_t cmd;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (pending_cmds.size() != 0 &&
          (calm_stretch || $urandom_range(0, 99) >= IDLE_PCT)) begin
        cmd            = pending_cmds.pop_front();
        in_action     <= cmd.action;
        in_operand_hi <= cmd.hi;
        in_operand_lo <= cmd.lo;
        start         <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor and predictor tap in one process: check the result beat against the
  // oldest expectation first, then log the expectation of a beat taken on this edge.
  always @(posedge clk) begin : frame_checker
    frame_view_t want;
    frame_view_t seen;
    beat_taken = 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        seen = '{out_status, out_top_word, out_below_word, out_stack_depth};
        results_seen++;
        if (expected_views.size() == 0) begin
          $error("result beat with no command outstanding");
          mismatches++;
        end else begin
          want = expected_views.pop_front();
          status_hits[want.status]++;
          if (seen.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, seen.status);
            mismatches++;
          end
          if (seen.top !== want.top) begin
            $error("top_word: expected %08h, got %08h", want.top, seen.top);
            mismatches++;
          end
          if (seen.below !== want.below) begin
            $error("below_word: expected %08h, got %08h", want.below, seen.below);
            mismatches++;
          end
          if (seen.depth !== want.depth) begin
            $error("stack_depth: expected %0d, got %0d", want.depth, seen.depth);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        expected_views.push_back(exec_bytecode(in_action, in_operand_hi, in_operand_lo));
        beat_taken = 1'b1;
        beats_accepted++;
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : sequencer
    int phase_slots [PHASES];
    int phase_store_pct [PHASES];
    phase_slots     = '{256, 1, 255, 4, 128, 256};
    phase_store_pct = '{20, 35, 30, 30, 35, 45};
    phase_slots[4]  = $urandom_range(5, 250);
    foreach (stack_mirror[i]) stack_mirror[i] = '0;
    foreach (local_mirror[i]) local_mirror[i] = '0;
    stack_ptr    = 0;
    locals_limit = LOCAL_SLOTS;

    // Hold reset, then release it at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait_drained();
    program_locals(LOCAL_SLOTS);

    // Directed: underflow on an empty stack, a never-written local, every constant
    // push (including the two-word constants with a nonzero half), sign extension
    // limits, two-word stores at the top of the local range, unsupported opcodes.
    queue_cmd(OP_ISTORE_0, 8'h00, 8'h00);
    queue_cmd(OP_ILOAD, 8'h00, 8'h00);
    for (int op = OP_ACONST_NULL; op <= OP_DCONST_1; op++) queue_cmd(8'(op), 8'h00, 8'h00);
    queue_cmd(OP_BIPUSH, 8'h80, 8'h00);
    queue_cmd(OP_BIPUSH, 8'h7F, 8'hFF);
    queue_cmd(OP_SIPUSH, 8'h80, 8'h00);
    queue_cmd(OP_SIPUSH, 8'h7F, 8'hFF);
    queue_cmd(OP_LSTORE, 8'hFE, 8'h00);
    queue_cmd(OP_DSTORE, 8'hFF, 8'h00);
    queue_cmd(OP_ISTORE, 8'hFF, 8'h00);
    queue_cmd(OP_LLOAD, 8'hFE, 8'h00);
    queue_cmd(OP_DLOAD, 8'hFF, 8'h00);
    queue_cmd(OP_ALOAD_3, 8'h00, 8'h00);
    queue_cmd(OP_DSTORE_2, 8'h00, 8'h00);
    queue_cmd(OP_NOP, 8'h00, 8'h00);
    queue_cmd(OP_LDC, 8'h01, 8'h00);
    queue_cmd(OP_ILLEGAL, 8'hFF, 8'hFF);
    wait_drained();

    // Random phases: each with its own slot count and push/store balance, so the
    // stack swings between empty and full. One phase runs with no idle cycles.
    for (int ph = 0; ph < PHASES; ph++) begin
      program_locals(phase_slots[ph]);
      calm_stretch = (ph == CALM_PHASE);
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        pending_cmds.push_back(random_bytecode(phase_store_pct[ph], phase_slots[ph]));
      wait_drained();
    end
    calm_stretch = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d command beats and checked %0d results over %0d local-slot settings.",
             beats_accepted, results_seen, settings_used);
    $display("Status mix: ok %0d, overflow %0d, underflow %0d, bad local %0d, unsupported %0d.",
             status_hits[ST_OK], status_hits[ST_OVER], status_hits[ST_UNDER],
             status_hits[ST_BADLOC], status_hits[ST_UNSUP]);
    if (mismatches == 0 && expected_views.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
